// ===== rtl/rc_receiver_frame_decoder_top_assert.svh =====
// Assertion macros for the remote-control frame decoder.
// Used by the top level only; expects a clock aclk and reset aresetn in scope.
`ifndef RC_RECEIVER_FRAME_DECODER_TOP_ASSERT_SVH
`define RC_RECEIVER_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rcfd_pkg.sv =====
// Shared types and constants for the remote-control frame decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rcfd_pkg;

    // Frame geometry and check constants.
    localparam int FRAME_LEN    = 18;
    localparam int CH_W         = 11;
    localparam int WIN_W        = 13;
    localparam int WINDOW_SLACK = 10;
    localparam logic [CH_W-1:0] FAILSAFE_CH = 11'd1024;

    // Configuration register reset values and widths.
    localparam int LIMIT_W = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CH_W-1:0]    CHANNEL_MIN_RESET = 11'd364;
    localparam logic [CH_W-1:0]    CHANNEL_MAX_RESET = 11'd1684;
    localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RESET  = 8'd10;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_MIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_MAX = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_LIMIT  = 2'd2;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_IDLE  = 2'd1,
        OP_ERROR = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // Decoded contents of one frame, also the held output record.
    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch3;
        logic [CH_W-1:0] ch4;
        logic [3:0]      switches;
        logic [15:0]     mouse_dx;
        logic [15:0]     mouse_dy;
        logic [15:0]     mouse_dz;
        logic [1:0]      buttons;
        logic [15:0]     keys;
    } held_t;

    // Command passed from front to back: load a frame or apply failsafe.
    typedef struct packed {
        logic  failsafe;
        held_t data;
    } cmd_t;

    // Failsafe record.
    localparam held_t FAILSAFE_HELD = '{
        ch0: FAILSAFE_CH, ch1: FAILSAFE_CH, ch2: FAILSAFE_CH,
        ch3: FAILSAFE_CH, ch4: FAILSAFE_CH,
        switches: 4'd0, mouse_dx: 16'd0, mouse_dy: 16'd0, mouse_dz: 16'd0,
        buttons: 2'd0, keys: 16'd0
    };

endpackage

// ===== rtl/rcfd_front.sv =====
// Front end: takes input items, assembles and checks frames, counts ticks.
// Depends on rcfd_pkg; feeds commands into rcfd_queue.
`timescale 1ns / 1ps

module rcfd_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_operation,
    input  logic [7:0]                             s_data_byte,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rcfd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   q_full,
    output logic                                   push,
    output rcfd_pkg::cmd_t                         push_cmd
);

    localparam int StoreLen = rcfd_pkg::FRAME_LEN - 1;
    localparam int CountW   = $clog2(rcfd_pkg::FRAME_LEN);

    logic [rcfd_pkg::CH_W-1:0]    channel_min_reg;
    logic [rcfd_pkg::CH_W-1:0]    channel_max_reg;
    logic [rcfd_pkg::LIMIT_W-1:0] fail_limit_reg;

    logic [7:0]                   frame_reg [StoreLen];
    logic [CountW-1:0]            byte_count_reg;
    logic [CountW-1:0]            byte_count_next;
    logic [rcfd_pkg::LIMIT_W-1:0] tick_count_reg;
    logic [rcfd_pkg::LIMIT_W-1:0] tick_count_next;

    rcfd_pkg::op_t                op;
    logic                         accept;
    logic                         last_byte;
    logic                         tick_fail;
    logic                         frame_ok;
    logic [47:0]                  head;
    logic [3:0]                   sw;
    logic signed [rcfd_pkg::WIN_W-1:0] win_lo;
    logic signed [rcfd_pkg::WIN_W-1:0] win_hi;
    rcfd_pkg::held_t              decoded;

    function automatic logic in_window(
        input logic [rcfd_pkg::CH_W-1:0]          v,
        input logic signed [rcfd_pkg::WIN_W-1:0]  lo,
        input logic signed [rcfd_pkg::WIN_W-1:0]  hi
    );
        logic signed [rcfd_pkg::WIN_W-1:0] sv;
        sv = $signed({2'b00, v});
        return (sv >= lo) && (sv <= hi);
    endfunction

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign op        = rcfd_pkg::op_t'(s_operation);

    // Window bounds in signed arithmetic so a low minimum accepts everything.
    assign win_lo = $signed({2'b00, channel_min_reg})
                    - rcfd_pkg::WIN_W'(rcfd_pkg::WINDOW_SLACK);
    assign win_hi = $signed({2'b00, channel_max_reg})
                    + rcfd_pkg::WIN_W'(rcfd_pkg::WINDOW_SLACK);

    // Bit stream of the first six bytes holds the four sticks and switches.
    assign head = {frame_reg[5], frame_reg[4], frame_reg[3],
                   frame_reg[2], frame_reg[1], frame_reg[0]};
    assign sw   = head[47:44];

    // Decode the frame; the last byte comes straight from the input.
    always_comb begin
        decoded.ch0      = head[10:0];
        decoded.ch1      = head[21:11];
        decoded.ch2      = head[32:22];
        decoded.ch3      = head[43:33];
        decoded.ch4      = {s_data_byte[2:0], frame_reg[16]};
        decoded.switches = sw;
        decoded.mouse_dx = {frame_reg[7], frame_reg[6]};
        decoded.mouse_dy = {frame_reg[9], frame_reg[8]};
        decoded.mouse_dz = {frame_reg[11], frame_reg[10]};
        decoded.buttons  = {frame_reg[13][0], frame_reg[12][0]};
        decoded.keys     = {frame_reg[15], frame_reg[14]};
    end

    // Frame check: sticks in window, both switches set, buttons 0 or 1.
    assign frame_ok = in_window(decoded.ch0, win_lo, win_hi)
                   && in_window(decoded.ch1, win_lo, win_hi)
                   && in_window(decoded.ch2, win_lo, win_hi)
                   && in_window(decoded.ch3, win_lo, win_hi)
                   && (sw[1:0] != 2'd0) && (sw[3:2] != 2'd0)
                   && (frame_reg[12][7:1] == 7'd0) && (frame_reg[13][7:1] == 7'd0);

    assign last_byte = (byte_count_reg == CountW'(StoreLen));
    assign tick_fail = (tick_count_reg >= fail_limit_reg);

    // A command goes to the back on a good frame or a failsafe tick.
    always_comb begin
        push              = 1'b0;
        push_cmd.failsafe = (op == rcfd_pkg::OP_TICK);
        push_cmd.data     = decoded;
        if (accept) begin
            unique case (op)
                rcfd_pkg::OP_BYTE:  push = last_byte && frame_ok;
                rcfd_pkg::OP_TICK:  push = tick_fail;
                default:            push = 1'b0;
            endcase
        end
    end

    // Next byte and tick counts.
    always_comb begin
        byte_count_next = byte_count_reg;
        tick_count_next = tick_count_reg;
        if (accept) begin
            unique case (op)
                rcfd_pkg::OP_BYTE: begin
                    if (last_byte) begin
                        byte_count_next = '0;
                        if (frame_ok) begin
                            tick_count_next = '0;
                        end
                    end else begin
                        byte_count_next = byte_count_reg + CountW'(1);
                    end
                end
                rcfd_pkg::OP_IDLE, rcfd_pkg::OP_ERROR: begin
                    byte_count_next = '0;
                end
                rcfd_pkg::OP_TICK: begin
                    if (tick_fail) begin
                        tick_count_next = fail_limit_reg;
                        byte_count_next = '0;
                    end else begin
                        tick_count_next = tick_count_reg + rcfd_pkg::LIMIT_W'(1);
                    end
                end
                default: begin
                    byte_count_next = byte_count_reg;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            tick_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            tick_count_reg <= tick_count_next;
        end
    end

    // Frame byte store; the final byte is never stored.
    always_ff @(posedge aclk) begin
        if (accept && (op == rcfd_pkg::OP_BYTE) && !last_byte) begin
            frame_reg[byte_count_reg] <= s_data_byte;
        end
    end

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_min_reg <= rcfd_pkg::CHANNEL_MIN_RESET;
            channel_max_reg <= rcfd_pkg::CHANNEL_MAX_RESET;
            fail_limit_reg  <= rcfd_pkg::FAIL_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rcfd_pkg::CFG_CHANNEL_MIN: channel_min_reg <= cfg_data[rcfd_pkg::CH_W-1:0];
                rcfd_pkg::CFG_CHANNEL_MAX: channel_max_reg <= cfg_data[rcfd_pkg::CH_W-1:0];
                rcfd_pkg::CFG_FAIL_LIMIT:  fail_limit_reg  <= cfg_data[rcfd_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/rcfd_queue.sv =====
// Small command queue between the front and the back of the decoder.
// Depends on rcfd_pkg for the command type.
`timescale 1ns / 1ps

module rcfd_queue #(
    parameter int Depth = rcfd_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rcfd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output rcfd_pkg::cmd_t q_cmd
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    rcfd_pkg::cmd_t  entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointer and fill tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/rcfd_back.sv =====
// Back end: applies load and failsafe commands to the held data and presents it.
// Depends on rcfd_pkg; reads commands from rcfd_queue.
`timescale 1ns / 1ps

module rcfd_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  rcfd_pkg::cmd_t            q_cmd,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rcfd_pkg::held_t           held,
    output logic                      link_up
);

    rcfd_pkg::held_t held_reg;
    logic            link_reg;
    logic            m_valid_reg;

    // Take a command whenever the output register is free or being drained.
    assign pop     = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign held    = held_reg;
    assign link_up = link_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Held data: a good frame replaces it, failsafe forces the safe record.
    always_ff @(posedge aclk) begin
        if (pop) begin
            held_reg <= q_cmd.failsafe ? rcfd_pkg::FAILSAFE_HELD : q_cmd.data;
            link_reg <= !q_cmd.failsafe;
        end
    end

endmodule

// ===== rtl/rc_receiver_frame_decoder_top.sv =====
// Channel   | Handshake          | Payload
// s_        | s_valid / s_ready  | s_operation, s_data_byte
// m_        | m_valid / m_ready  | held sticks, switches, mouse, buttons, keys, link_up
// cfg_      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One input item is taken per cycle while s_ready is high. A result is registered in
// the queue, then the result register; the back loads one command a cycle unless a
// held result waits on m_ready. The front decides each item combinationally.
// s_ready falls only when the command queue is full behind a stalled m_ready.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
// Top level of the remote-control frame decoder; depends on rcfd_pkg,
// rcfd_front, rcfd_queue, rcfd_back and the assertion macro header.
`timescale 1ns / 1ps

module rc_receiver_frame_decoder_top #(
    parameter int QueueDepth = rcfd_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [7:0]                         s_data_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [10:0]                        m_stick_ch0,
    output logic [10:0]                        m_stick_ch1,
    output logic [10:0]                        m_stick_ch2,
    output logic [10:0]                        m_stick_ch3,
    output logic [10:0]                        m_wheel_ch4,
    output logic [3:0]                         m_switches,
    output logic signed [15:0]                 m_mouse_dx,
    output logic signed [15:0]                 m_mouse_dy,
    output logic signed [15:0]                 m_mouse_dz,
    output logic [1:0]                         m_mouse_buttons,
    output logic [15:0]                        m_key_bits,
    output logic                               m_link_up,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rcfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "rc_receiver_frame_decoder_top_assert.svh"

    logic            push;
    rcfd_pkg::cmd_t  push_cmd;
    logic            q_full;
    logic            pop;
    logic            q_valid;
    rcfd_pkg::cmd_t  q_cmd;
    rcfd_pkg::held_t held;

    // Front: frame assembly, checking and tick counting.
    rcfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_data_byte (s_data_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Command queue.
    rcfd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // Back: held data and result register.
    rcfd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .held    (held),
        .link_up (m_link_up)
    );

    // Result fields.
    assign m_stick_ch0     = held.ch0;
    assign m_stick_ch1     = held.ch1;
    assign m_stick_ch2     = held.ch2;
    assign m_stick_ch3     = held.ch3;
    assign m_wheel_ch4     = held.ch4;
    assign m_switches      = held.switches;
    assign m_mouse_dx      = $signed(held.mouse_dx);
    assign m_mouse_dy      = $signed(held.mouse_dy);
    assign m_mouse_dz      = $signed(held.mouse_dz);
    assign m_mouse_buttons = held.buttons;
    assign m_key_bits      = held.keys;

    // A connected result always carries two nonzero switches.
    `RCFD_ASSERT_NOW(a_link_switches, m_valid && m_link_up,
        (m_switches[1:0] != 2'd0) && (m_switches[3:2] != 2'd0),
        "connected result with a zero switch")

    // A disconnected result carries the failsafe record.
    `RCFD_ASSERT_NOW(a_failsafe_record, m_valid && !m_link_up,
        (m_stick_ch0 == rcfd_pkg::FAILSAFE_CH) && (m_key_bits == 16'd0)
        && (m_switches == 4'd0),
        "failsafe result with non-failsafe data")

    // The result register empties when taken with nothing queued behind it.
    `RCFD_ASSERT_NEXT(a_drain, m_valid && m_ready && !q_valid, !m_valid,
        "result held after being taken with an empty queue")

endmodule
